// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off during reset
`define CHK_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/spifcs_pkg.sv =====
// shared types and codes of the spi flash command sequencer
package spifcs_pkg;
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_PROG  = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_HOST  = 3'd3;
    localparam logic [2:0] OP_REPLY = 3'd4;

    localparam logic [2:0] K_XFER   = 3'd0;
    localparam logic [2:0] K_CSREL  = 3'd1;
    localparam logic [2:0] K_DATA   = 3'd2;
    localparam logic [2:0] K_DONE   = 3'd3;
    localparam logic [2:0] K_REJECT = 3'd4;

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_READ_WAIT    = 3'd1;
    localparam logic [2:0] PH_PROG_DATA    = 3'd2;
    localparam logic [2:0] PH_PROG_STATUS  = 3'd3;
    localparam logic [2:0] PH_ERASE_STATUS = 3'd4;

    localparam logic [1:0] REG_PAGE  = 2'd0;
    localparam logic [1:0] REG_ERASE = 2'd1;
    localparam logic [1:0] REG_FLASH = 2'd2;

    localparam logic [7:0] CMD_PROG   = 8'h02;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_STATUS = 8'h05;
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_ERASE  = 8'hd8;
    localparam logic [7:0] WIP_MASK   = 8'h01;

    localparam int MAX_RES = 12;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       want_reply;
    } t_ent;

    typedef struct packed {
        logic [2:0]  phase;
        logic [23:0] cur_address;
        logic [24:0] bytes_left;
        logic [16:0] chunk_left;
        logic [24:0] bytes_done;
    } t_st;

    typedef struct packed {
        logic [4:0] page_log2;
        logic [4:0] erase_log2;
        logic [4:0] flash_log2;
    } t_cfg;
endpackage

// ===== src/spifcs_plan.sv =====
// works out the result list and next state for one input word
module spifcs_plan #(
    parameter int ADDRESS_BITS = 24
) (
    input  spifcs_pkg::t_st  i_st,
    input  spifcs_pkg::t_cfg i_cfg,
    input  logic [2:0]       i_opcode,
    input  logic [23:0]      i_address,
    input  logic [24:0]      i_length,
    input  logic [7:0]       i_data_byte,
    output spifcs_pkg::t_st  o_st,
    output spifcs_pkg::t_ent o_list [spifcs_pkg::MAX_RES],
    output logic [3:0]       o_num
);
    import spifcs_pkg::*;

    localparam logic [23:0] AMASK = 24'((25'd1 << ADDRESS_BITS) - 25'd1);

    logic [4:0]  pl, el, fl;
    logic [16:0] ps;
    logic [24:0] es;
    logic [25:0] fs;
    t_st         s;
    t_ent        lst [MAX_RES];
    logic [3:0]  n;
    logic [23:0] addr;
    logic [16:0] room;
    logic [25:0] aend;
    logic [24:0] adv;

    function automatic t_ent ent(input logic [2:0] k, input logic [7:0] b, input logic r);
        t_ent e;
        e.kind = k;
        e.byte_value = b;
        e.want_reply = r;
        return e;
    endfunction

    always_comb begin
        pl = (i_cfg.page_log2 > 5'd16) ? 5'd16 : i_cfg.page_log2;
        el = (i_cfg.erase_log2 > 5'd24) ? 5'd24 : i_cfg.erase_log2;
        fl = (i_cfg.flash_log2 > 5'(ADDRESS_BITS)) ? 5'(ADDRESS_BITS) : i_cfg.flash_log2;
        ps = 17'd1 << pl;
        es = 25'd1 << el;
        fs = 26'd1 << fl;
        addr = i_address & AMASK;
        aend = {2'b00, addr} + {1'b0, i_length};
        s = i_st;
        n = 4'd0;
        room = '0;
        adv = '0;
        for (int k = 0; k < MAX_RES; k++) lst[k] = ent(K_XFER, 8'h00, 1'b0);

        if (i_opcode == OP_READ || i_opcode == OP_PROG || i_opcode == OP_ERASE) begin
            if (s.phase != PH_IDLE) begin
                lst[n] = ent(K_REJECT, 8'h00, 1'b0); n = n + 4'd1;
            end else begin
                s.cur_address = addr;
                s.bytes_done = '0;
                if (i_opcode == OP_READ) begin
                    s.bytes_left = i_length;
                    if (i_length == '0) begin
                        lst[n] = ent(K_DONE, 8'h00, 1'b0); n = n + 4'd1;
                        s.phase = PH_IDLE;
                    end else begin
                        s.chunk_left = (s.bytes_left < {8'd0, ps}) ? s.bytes_left[16:0] : ps;
                        lst[n] = ent(K_XFER, CMD_READ, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[23:16], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[15:8], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[7:0], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
                        s.phase = PH_READ_WAIT;
                    end
                end else if (aend > fs) begin
                    lst[n] = ent(K_REJECT, 8'h00, 1'b0); n = n + 4'd1;
                end else if (i_opcode == OP_PROG) begin
                    s.bytes_left = i_length;
                    if (i_length == '0) begin
                        lst[n] = ent(K_DONE, 8'h00, 1'b0); n = n + 4'd1;
                        s.phase = PH_IDLE;
                    end else begin
                        room = ps - (s.cur_address[16:0] & (ps - 17'd1));
                        s.chunk_left = (s.bytes_left < {8'd0, room}) ? s.bytes_left[16:0] : room;
                        lst[n] = ent(K_XFER, CMD_WREN, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, CMD_PROG, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[23:16], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[15:8], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[7:0], 1'b0); n = n + 4'd1;
                        s.phase = PH_PROG_DATA;
                    end
                end else if (({1'b0, addr} & (es - 25'd1)) != '0) begin
                    lst[n] = ent(K_REJECT, 8'h00, 1'b0); n = n + 4'd1;
                end else begin
                    s.bytes_left = i_length & ~(es - 25'd1);
                    if (s.bytes_left == '0) begin
                        lst[n] = ent(K_DONE, 8'h00, 1'b0); n = n + 4'd1;
                        s.phase = PH_IDLE;
                    end else begin
                        lst[n] = ent(K_XFER, CMD_WREN, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, CMD_ERASE, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[23:16], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[15:8], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, s.cur_address[7:0], 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, CMD_STATUS, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
                        s.phase = PH_ERASE_STATUS;
                    end
                end
            end
        end else if (i_opcode == OP_HOST && s.phase == PH_PROG_DATA) begin
            lst[n] = ent(K_XFER, i_data_byte, 1'b0); n = n + 4'd1;
            s.bytes_done = s.bytes_done + 25'd1;
            s.bytes_left = (s.bytes_left != '0) ? s.bytes_left - 25'd1 : '0;
            s.cur_address = (s.cur_address + 24'd1) & AMASK;
            if (s.chunk_left != '0) s.chunk_left = s.chunk_left - 17'd1;
            if (s.chunk_left == '0) begin
                lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, CMD_STATUS, 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
                s.phase = PH_PROG_STATUS;
            end
        end else if (i_opcode == OP_REPLY && s.phase == PH_READ_WAIT) begin
            lst[n] = ent(K_DATA, i_data_byte, 1'b0); n = n + 4'd1;
            s.bytes_done = s.bytes_done + 25'd1;
            s.bytes_left = (s.bytes_left != '0) ? s.bytes_left - 25'd1 : '0;
            s.cur_address = (s.cur_address + 24'd1) & AMASK;
            if (s.chunk_left != '0) s.chunk_left = s.chunk_left - 17'd1;
            if (s.bytes_left == '0) begin
                lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                lst[n] = ent(K_DONE, 8'h00, 1'b0); n = n + 4'd1;
                s.phase = PH_IDLE;
            end else if (s.chunk_left == '0) begin
                lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                s.chunk_left = (s.bytes_left < {8'd0, ps}) ? s.bytes_left[16:0] : ps;
                lst[n] = ent(K_XFER, CMD_READ, 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, s.cur_address[23:16], 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, s.cur_address[15:8], 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, s.cur_address[7:0], 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
            end else begin
                lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
            end
        end else if (i_opcode == OP_REPLY &&
                     (s.phase == PH_PROG_STATUS || s.phase == PH_ERASE_STATUS)) begin
            lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
            if ((i_data_byte & WIP_MASK) != '0) begin
                lst[n] = ent(K_XFER, CMD_STATUS, 1'b0); n = n + 4'd1;
                lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
            end else begin
                if (s.phase == PH_ERASE_STATUS) begin
                    adv = es;
                    s.bytes_done = s.bytes_done + adv;
                    s.bytes_left = (s.bytes_left >= adv) ? s.bytes_left - adv : '0;
                    s.cur_address = (s.cur_address + adv[23:0]) & AMASK;
                end
                if (s.bytes_left == '0) begin
                    lst[n] = ent(K_DONE, 8'h00, 1'b0); n = n + 4'd1;
                    s.phase = PH_IDLE;
                end else begin
                    lst[n] = ent(K_XFER, CMD_WREN, 1'b0); n = n + 4'd1;
                    lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                    if (s.phase == PH_PROG_STATUS) begin
                        room = ps - (s.cur_address[16:0] & (ps - 17'd1));
                        s.chunk_left = (s.bytes_left < {8'd0, room}) ?
                                       s.bytes_left[16:0] : room;
                        lst[n] = ent(K_XFER, CMD_PROG, 1'b0); n = n + 4'd1;
                    end else begin
                        lst[n] = ent(K_XFER, CMD_ERASE, 1'b0); n = n + 4'd1;
                    end
                    lst[n] = ent(K_XFER, s.cur_address[23:16], 1'b0); n = n + 4'd1;
                    lst[n] = ent(K_XFER, s.cur_address[15:8], 1'b0); n = n + 4'd1;
                    lst[n] = ent(K_XFER, s.cur_address[7:0], 1'b0); n = n + 4'd1;
                    if (s.phase == PH_PROG_STATUS) begin
                        s.phase = PH_PROG_DATA;
                    end else begin
                        lst[n] = ent(K_CSREL, 8'h00, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, CMD_STATUS, 1'b0); n = n + 4'd1;
                        lst[n] = ent(K_XFER, 8'h00, 1'b1); n = n + 4'd1;
                    end
                end
            end
        end
        o_st = s;
        o_list = lst;
        o_num = n;
    end
endmodule

// ===== src/spi_flash_command_sequencer.sv =====
// top level of the spi flash command sequencer
//
// input channel (i_valid/o_ready): read, program and erase requests, host data
// words to program and flash reply words. output channel (o_valid/i_ready):
// spi transfers, chip select releases, read data, done and reject results.
// configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0 page size log2, 1 erase size log2, 2 flash size log2); the user must
// write it only while idle; the block does not enforce it. an accepted word
// is decoded combinationally into a list of up to ten results, which appear
// on the output from the next cycle, one per cycle while the receiver is
// ready; o_last marks the final one. a word that causes no result is absorbed.
// throughput is one word per cycle for single-result words and otherwise one
// word per result list, while the receiver is ready: the next word is taken
// in the cycle its predecessor's last result leaves. a stalled receiver holds
// the current result, and input waits while any result of the list is pending
// until its last one is taken. reset (synchronous) returns the sequencer to
// idle, empties the output and restores the configuration defaults.
module spi_flash_command_sequencer #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [23:0] i_address,
    input  logic [24:0] i_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_want_reply,
    output logic [24:0] o_count,
    output logic        o_last
);
    import spifcs_pkg::*;
    `include "assert_macros.svh"

    t_cfg       r_cfg;
    t_st        r_st, n_st;
    t_ent       r_list [MAX_RES];
    t_ent       n_list [MAX_RES];
    logic [3:0] r_num, n_num;
    logic [3:0] r_idx;
    logic       r_busy;
    logic [24:0] r_cnt;
    t_ent       cur;
    logic       in_acc, out_acc, at_last;

    spifcs_plan #(.ADDRESS_BITS(ADDRESS_BITS)) u_plan (
        .i_st       (r_st),
        .i_cfg      (r_cfg),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .i_length   (i_length),
        .i_data_byte(i_data_byte),
        .o_st       (n_st),
        .o_list     (n_list),
        .o_num      (n_num)
    );

    assign cur     = r_list[r_idx];
    assign at_last = (r_idx == r_num - 4'd1);
    assign out_acc = r_busy && i_ready;
    assign o_ready = !r_busy || (i_ready && at_last);
    assign in_acc  = i_valid && o_ready;

    assign o_valid      = r_busy;
    assign o_kind       = cur.kind;
    assign o_byte_value = cur.byte_value;
    assign o_want_reply = cur.want_reply;
    assign o_count      = (cur.kind == K_DONE) ? r_cnt : '0;
    assign o_last       = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_log2  <= 5'd8;
            r_cfg.erase_log2 <= 5'd16;
            r_cfg.flash_log2 <= 5'd23;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAGE:  r_cfg.page_log2  <= i_cfg_wdata;
                REG_ERASE: r_cfg.erase_log2 <= i_cfg_wdata;
                REG_FLASH: r_cfg.flash_log2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_num  <= '0;
        end else if (in_acc) begin
            r_st   <= n_st;
            r_busy <= (n_num != '0);
            r_idx  <= '0;
            r_num  <= n_num;
        end else if (out_acc) begin
            if (at_last) r_busy <= 1'b0;
            else r_idx <= r_idx + 4'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_list <= n_list;
            r_cnt  <= n_st.bytes_done;
        end
    end

    `CHK_CLK(a_idx_range, i_clk, i_rst_n, !r_busy || (r_idx < r_num), "index beyond list")
    `CHK_CLK(a_no_overrun, i_clk, i_rst_n, !(in_acc && r_busy && !(out_acc && at_last)), "input taken over pending results")
    `CHK_CLK(a_done_last, i_clk, i_rst_n, !(o_valid && (o_kind == K_DONE)) || o_last, "done not final")
    `CHK_CLK(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_valid, "output valid after reset")
endmodule
